// ----- src/visible_region_priority_list_assert.svh -----
// Assertion macros for the visible region priority list block
`ifndef VISIBLE_REGION_PRIORITY_LIST_ASSERT_SVH
`define VISIBLE_REGION_PRIORITY_LIST_ASSERT_SVH
`ifndef SYNTHESIS
`define VRPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VRPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VRPL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VRPL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/vrpl_pkg.sv -----
// Types and constants shared by the visible region priority list block
package vrpl_pkg;
    localparam int COORD_W = 15;
    localparam int BOX_W   = 12;
    localparam int PIX_W   = 10;
    localparam int REG_W   = 8;
    localparam int DIST_W  = 31;
    localparam int COUNT_W = 7;
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = 6;
    localparam int DIV_W   = 20;
    localparam int DSOR_W  = 11;
    localparam int KEY_W   = DIST_W + 2 * REG_W;
    localparam int WIN_W   = 22;

    localparam logic [1:0] CFG_LOW_X  = 2'd0;
    localparam logic [1:0] CFG_HIGH_X = 2'd1;
    localparam logic [1:0] CFG_LOW_Y  = 2'd2;
    localparam logic [1:0] CFG_HIGH_Y = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_DIV_STORE,
        ST_CLAMP,
        ST_DELTA,
        ST_SQ_X,
        ST_SQ_Z,
        ST_SCAN,
        ST_EMIT
    } state_t;
endpackage

// ----- src/visible_region_priority_list.sv -----
// Visible region priority list: viewport window, distance list and sorted emit
// Sequence: window arithmetic, then delta and squarer steps for x and z per
// listed region, then per entry a full scan of the list and an emit beat.
// Throughput: one request at a time; in_ready is high only while idle.
// Reset: bounds return to 0..255 on both axes, the sequencer goes idle and
// no result is pending; the entry memory is not cleared.
module visible_region_priority_list #(
    parameter int REGION_TILES_X = 64,
    parameter int REGION_TILES_Z = 64,
    parameter int MAX_VISITS     = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [7:0]                        cfg_index,
    input  logic [vrpl_pkg::REG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [vrpl_pkg::COORD_W-1:0] view_tile_x,
    input  logic signed [vrpl_pkg::COORD_W-1:0] centre_tile_z,
    input  logic [vrpl_pkg::BOX_W-1:0]        box_width,
    input  logic [vrpl_pkg::BOX_W-1:0]        box_height,
    input  logic [vrpl_pkg::PIX_W-1:0]        pixels_per_region,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vrpl_pkg::REG_W-1:0]        region_col,
    output logic [vrpl_pkg::REG_W-1:0]        region_row,
    output logic [vrpl_pkg::DIST_W-1:0]       centre_distance_sq,
    output logic [vrpl_pkg::COUNT_W-1:0]      list_count,
    output logic                              last_entry
);
    import vrpl_pkg::*;
    `include "visible_region_priority_list_assert.svh"

    localparam logic [8:0] RTX = 9'(REGION_TILES_X);
    localparam logic [8:0] RTZ = 9'(REGION_TILES_Z);
    localparam logic [COUNT_W-1:0] MAXV = COUNT_W'(MAX_VISITS);

    // Reciprocals of the region sizes; exact for numerators below 2^20
    localparam int RECIP_SH = 29;
    localparam logic [27:0] MUL_X = 28'(((64'd1 << RECIP_SH) + 64'(REGION_TILES_X) - 64'd1)
                                        / 64'(REGION_TILES_X));
    localparam logic [27:0] MUL_Z = 28'(((64'd1 << RECIP_SH) + 64'(REGION_TILES_Z) - 64'd1)
                                        / 64'(REGION_TILES_Z));

    state_t state_reg, state_next;

    // configuration bounds
    logic [REG_W-1:0] low_x_reg, high_x_reg, low_y_reg, high_y_reg;

    // captured request
    logic signed [COORD_W-1:0] cx_reg, cz_reg;
    logic [BOX_W-1:0]          bw_reg, bh_reg;
    logic [PIX_W-1:0]          px_reg;

    // shared restoring divider
    logic [2:0]          phase_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [DSOR_W-1:0]   rem_reg, dsor_reg;
    logic [4:0]          dcnt_reg;
    logic                neg_reg;
    logic [DSOR_W:0]     rem_sh;
    logic                fits;
    logic signed [WIN_W-1:0] num_s;
    logic [WIN_W-1:0]    num_mag;
    logic signed [WIN_W-1:0] quo_s;

    // reciprocal path for the window edges
    logic [27:0]         rmul;
    logic [47:0]         recip_prod;
    logic [DIV_W-1:0]    recip_q;

    logic [DIV_W-1:0]        halfx_reg, halfz_reg;
    logic signed [WIN_W-1:0] rx0_reg, rx1_reg, ry0_reg, ry1_reg;

    // window walk
    logic signed [WIN_W-1:0] lx, hx, ly, hy;
    logic [REG_W-1:0] x0_reg, x1_reg, y1_reg, x_reg, y_reg;
    logic [COUNT_W-1:0] n_reg;
    logic signed [18:0] dx_reg, dz_reg;
    logic signed [18:0] mul_a;
    logic signed [37:0] prod;
    logic [35:0]        sq_reg;
    logic [36:0]        dsum;
    logic [DIST_W-1:0]  dist_sat;

    // entry memory
    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] mem_q;
    logic             mem_we;

    // selection scan
    logic [COUNT_W-1:0] idx_reg, emit_cnt_reg;
    logic               rd_valid_reg, have_best_reg, have_last_reg;
    logic [KEY_W-1:0]   best_reg, last_key_reg, best_next;
    logic               cand_ok;

    // output register
    logic [REG_W-1:0]   col_reg, row_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               last_reg;

    logic degenerate;
    logic walk_done;

    assign degenerate = (pixels_per_region == '0) || (box_width == '0)
                        || (box_height == '0);

    // Numerator for each phase: two half-widths go through the divider, then
    // the four window edges are divided by the region size.
    always_comb
    begin
        num_s = '0;
        case (phase_reg)
            3'd0: num_s = WIN_W'($signed({1'b0, 21'(bw_reg * RTX)}));
            3'd1: num_s = WIN_W'($signed({1'b0, 21'(bh_reg * RTZ)}));
            3'd2: num_s = WIN_W'(cx_reg) - $signed({2'b0, halfx_reg})
                          - $signed({13'b0, RTX});
            3'd3: num_s = WIN_W'(cx_reg) + $signed({2'b0, halfx_reg})
                          + $signed({13'b0, RTX});
            3'd4: num_s = WIN_W'(cz_reg) - $signed({2'b0, halfz_reg})
                          - $signed({13'b0, RTZ});
            3'd5: num_s = WIN_W'(cz_reg) + $signed({2'b0, halfz_reg})
                          + $signed({13'b0, RTZ});
            default: num_s = '0;
        endcase
        num_mag = num_s[WIN_W-1] ? WIN_W'(-num_s) : WIN_W'(num_s);
    end

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dsor_reg};
    assign quo_s  = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});

    // Divide the edge magnitude by the region size: multiply by the reciprocal
    assign rmul       = (phase_reg < 3'd4) ? MUL_X : MUL_Z;
    assign recip_prod = 48'(num_mag[DIV_W-1:0]) * 48'(rmul);
    assign recip_q    = DIV_W'(recip_prod[47:RECIP_SH]);

    // Clamp the window to the configured bounds
    always_comb
    begin
        lx = (rx0_reg < $signed({14'b0, low_x_reg}))  ? $signed({14'b0, low_x_reg})  : rx0_reg;
        hx = (rx1_reg > $signed({14'b0, high_x_reg})) ? $signed({14'b0, high_x_reg}) : rx1_reg;
        ly = (ry0_reg < $signed({14'b0, low_y_reg}))  ? $signed({14'b0, low_y_reg})  : ry0_reg;
        hy = (ry1_reg > $signed({14'b0, high_y_reg})) ? $signed({14'b0, high_y_reg}) : ry1_reg;
    end

    // One squarer shared by both axes
    assign mul_a = (state_reg == ST_SQ_X) ? dx_reg : dz_reg;
    assign prod  = mul_a * mul_a;
    assign dsum  = {1'b0, sq_reg} + {1'b0, prod[35:0]};
    assign dist_sat = (dsum[36:DIST_W] != '0) ? '1 : dsum[DIST_W-1:0];

    assign walk_done = (n_reg + 7'd1 == MAXV) || ((x_reg == x1_reg) && (y_reg == y1_reg));
    assign mem_we    = (state_reg == ST_SQ_Z);

    // Keep the smallest key above the one emitted last
    assign cand_ok = rd_valid_reg && (!have_last_reg || (mem_q > last_key_reg))
                     && (!have_best_reg || (mem_q < best_reg));
    assign best_next = cand_ok ? mem_q : best_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = degenerate ? ST_EMIT : ST_DIV_LOAD;
            ST_DIV_LOAD:
                state_next = (phase_reg < 3'd2) ? ST_DIVIDE : ST_DIV_STORE;
            ST_DIVIDE:
                if (dcnt_reg == 5'(DIV_W - 1))
                    state_next = ST_DIV_STORE;
            ST_DIV_STORE:
                state_next = (phase_reg == 3'd5) ? ST_CLAMP : ST_DIV_LOAD;
            ST_CLAMP:
                state_next = ((lx > hx) || (ly > hy)) ? ST_EMIT : ST_DELTA;
            ST_DELTA:     state_next = ST_SQ_X;
            ST_SQ_X:      state_next = ST_SQ_Z;
            ST_SQ_Z:      state_next = walk_done ? ST_SCAN : ST_DELTA;
            ST_SCAN:
                if (idx_reg == n_reg)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_ready)
                    state_next = last_reg ? ST_IDLE : ST_SCAN;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        cfg_ready = 1'b1;
    end

    assign region_col         = col_reg;
    assign region_row         = row_reg;
    assign centre_distance_sq = dist_reg;
    assign list_count         = cnt_reg;
    assign last_entry         = last_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            low_x_reg     <= '0;
            high_x_reg    <= '1;
            low_y_reg     <= '0;
            high_y_reg    <= '1;
            phase_reg     <= '0;
            dcnt_reg      <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            emit_cnt_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            have_last_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_SCAN) && (idx_reg != n_reg);

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    8'(CFG_LOW_X):  low_x_reg  <= cfg_data;
                    8'(CFG_HIGH_X): high_x_reg <= cfg_data;
                    8'(CFG_LOW_Y):  low_y_reg  <= cfg_data;
                    8'(CFG_HIGH_Y): high_y_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        phase_reg     <= '0;
                        n_reg         <= '0;
                        emit_cnt_reg  <= '0;
                        have_last_reg <= 1'b0;
                        last_reg      <= 1'b1;
                    end
                ST_DIV_LOAD:  dcnt_reg <= '0;
                ST_DIVIDE:    dcnt_reg <= dcnt_reg + 5'd1;
                ST_DIV_STORE: phase_reg <= phase_reg + 3'd1;
                ST_CLAMP:     last_reg <= 1'b1;
                ST_SQ_Z:
                begin
                    n_reg <= n_reg + 7'd1;
                    if (walk_done)
                    begin
                        idx_reg       <= '0;
                        have_best_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    have_best_reg <= have_best_reg || cand_ok;
                    if (idx_reg == n_reg)
                    begin
                        last_reg      <= (emit_cnt_reg + 7'd1 == n_reg);
                        have_last_reg <= 1'b1;
                    end
                    else
                        idx_reg <= idx_reg + 7'd1;
                end
                ST_EMIT:
                    if (out_ready)
                    begin
                        emit_cnt_reg  <= emit_cnt_reg + 7'd1;
                        idx_reg       <= '0;
                        have_best_reg <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cx_reg <= view_tile_x;
                    cz_reg <= centre_tile_z;
                    bw_reg <= box_width;
                    bh_reg <= box_height;
                    px_reg <= pixels_per_region;
                    col_reg  <= '0;
                    row_reg  <= '0;
                    dist_reg <= '0;
                    cnt_reg  <= '0;
                end
            ST_DIV_LOAD:
            begin
                quo_reg  <= (phase_reg < 3'd2) ? num_mag[DIV_W-1:0] : recip_q;
                rem_reg  <= '0;
                neg_reg  <= num_s[WIN_W-1];
                dsor_reg <= {px_reg, 1'b0};
            end
            ST_DIVIDE:
            begin
                rem_reg <= fits ? DSOR_W'(rem_sh - {1'b0, dsor_reg}) : rem_sh[DSOR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
            end
            ST_DIV_STORE:
                case (phase_reg)
                    3'd0: halfx_reg <= quo_reg;
                    3'd1: halfz_reg <= quo_reg;
                    3'd2: rx0_reg   <= quo_s;
                    3'd3: rx1_reg   <= quo_s;
                    3'd4: ry0_reg   <= quo_s;
                    default: ry1_reg <= quo_s;
                endcase
            ST_CLAMP:
            begin
                x0_reg <= lx[REG_W-1:0];
                x1_reg <= hx[REG_W-1:0];
                y1_reg <= hy[REG_W-1:0];
                x_reg  <= lx[REG_W-1:0];
                y_reg  <= ly[REG_W-1:0];
            end
            ST_DELTA:
            begin
                dx_reg <= $signed({2'b0, 17'(x_reg * RTX)}) + $signed({11'b0, RTX[8:1]})
                          - 19'(cx_reg);
                dz_reg <= $signed({2'b0, 17'(y_reg * RTZ)}) + $signed({11'b0, RTZ[8:1]})
                          - 19'(cz_reg);
            end
            ST_SQ_X: sq_reg <= prod[35:0];
            ST_SQ_Z:
                if (x_reg == x1_reg)
                begin
                    x_reg <= x0_reg;
                    y_reg <= y_reg + 8'd1;
                end
                else
                    x_reg <= x_reg + 8'd1;
            ST_SCAN:
            begin
                best_reg <= best_next;
                if (idx_reg == n_reg)
                begin
                    col_reg      <= best_next[REG_W-1:0];
                    row_reg      <= best_next[2*REG_W-1:REG_W];
                    dist_reg     <= best_next[KEY_W-1:2*REG_W];
                    cnt_reg      <= n_reg;
                    last_key_reg <= best_next;
                end
            end
            default: ;
        endcase
    end

    // entry memory: written during the walk, read once a cycle during scans
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[n_reg[ADDR_W-1:0]] <= {dist_sat, y_reg, x_reg};
        mem_q <= mem[idx_reg[ADDR_W-1:0]];
    end

    `VRPL_ASSERT_IMP(a_one_at_a_time, clk, rst_n, in_ready, !out_valid)
    `VRPL_ASSERT_IMP(a_count_on_more, clk, rst_n, out_valid && !last_entry, list_count != '0)
    `VRPL_ASSERT_IMP(a_scan_has_entries, clk, rst_n, state_reg == ST_SCAN, n_reg != '0)
    `VRPL_ASSERT_NXT(a_busy_after_mid, clk, rst_n, out_valid && out_ready && !last_entry, !in_ready)
endmodule
